[hw/rtl/spc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package spc_pkg;

  localparam int POS_BITS   = 12;
  localparam int NUM_FLOORS = 6;
  localparam int TABLE_ROWS = 6;
  localparam int OP_W       = 2;
  localparam int FLOOR_W    = 3;
  localparam int HALF_W     = 16;
  localparam int DWELL_W    = 20;
  localparam int TIMER_W    = 20;
  localparam int CQ_DEPTH   = 4;
  localparam int CQ_AW      = 2;
  localparam int OQ_DEPTH   = 2;
  localparam int OQ_AW      = 1;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_HOME  = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;
  localparam logic [OP_W-1:0] OP_FLOOR = 2'd3;

  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_DWELL       = 1'b1;

  localparam logic [HALF_W-1:0]  HALF_RESET  = 16'd600;
  localparam logic [DWELL_W-1:0] DWELL_RESET = 20'd1000000;

  localparam int FLOOR_TABLE [TABLE_ROWS][2] = '{
    '{1600, 1650}, '{1250, 1300}, '{1020, 1070},
    '{770, 810},   '{500, 550},   '{250, 300}
  };

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [2:0] {
    K_TICK,
    K_HOME,
    K_MOVE,
    K_FLOOR,
    K_NOFLOOR
  } kind_t;

  typedef struct packed {
    kind_t kind;
    pos_t  tgt_a;
    pos_t  tgt_b;
    logic  sw;
  } cmd_t;

  typedef struct packed {
    logic step;
    logic dir;
    logic en;
    pos_t pos;
    logic busy;
    logic rejected;
  } res_t;

  typedef struct packed {
    logic [HALF_W-1:0]  half_period;
    logic [DWELL_W-1:0] dwell;
  } cfg_t;

  function automatic pos_t floor_target(input logic [FLOOR_W-1:0] fl, input logic second);
    pos_t val;
    val = '0;
    if (int'(fl) < TABLE_ROWS) begin
      val = second ? pos_t'(FLOOR_TABLE[fl][1]) : pos_t'(FLOOR_TABLE[fl][0]);
    end
    return val;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/spc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module spc_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [spc_pkg::OP_W-1:0]     op,
  input  wire logic [spc_pkg::POS_BITS-1:0] destination,
  input  wire logic [spc_pkg::FLOOR_W-1:0]  floor,
  input  wire logic                         switch_level,
  output logic                              cmd_valid,
  output spc_pkg::cmd_t                     cmd,
  input  wire logic                         cmd_full
);
  import spc_pkg::*;

  cmd_t decoded;
  logic accept;
  logic moving;

  assign moving = cmd_valid && !cmd_full;
  assign full   = cmd_valid && cmd_full;
  assign accept = push && !full;

  always_comb begin
    decoded       = '0;
    decoded.sw    = switch_level;
    decoded.tgt_a = destination;
    case (op)
      OP_TICK: decoded.kind = K_TICK;
      OP_HOME: decoded.kind = K_HOME;
      OP_MOVE: decoded.kind = K_MOVE;
      OP_FLOOR: begin
        if (int'(floor) < NUM_FLOORS && int'(floor) < TABLE_ROWS) begin
          decoded.kind  = K_FLOOR;
          decoded.tgt_a = floor_target(floor, 1'b0);
          decoded.tgt_b = floor_target(floor, 1'b1);
        end else begin
          decoded.kind = K_NOFLOOR;
        end
      end
      default: decoded.kind = K_TICK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (moving) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= decoded;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/spc_cmd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module spc_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  spc_pkg::cmd_t      cmd_in,
  output logic               full,
  input  wire logic          pop,
  output spc_pkg::cmd_t      cmd_out,
  output logic               valid
);
  import spc_pkg::*;

  cmd_t             slots [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr;
  logic [CQ_AW-1:0] rd_ptr;
  logic [CQ_AW:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (CQ_AW+1)'(CQ_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign cmd_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/spc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module spc_back (
  input  wire logic     clk,
  input  wire logic     rst,
  input  spc_pkg::cfg_t cfg,
  input  wire logic     cmd_valid,
  input  spc_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          empty,
  input  wire logic     pop,
  output spc_pkg::res_t result
);
  import spc_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE,
    M_HOME,
    M_MOVE,
    M_DWELL
  } mode_t;

  mode_t              mode, mode_next;
  pos_t               cur_pos, cur_pos_next;
  pos_t               target, target_next;
  pos_t               second_tgt, second_tgt_next;
  logic               pending, pending_next;
  logic               phase, phase_next;
  logic [TIMER_W-1:0] timer, timer_next;
  logic               enable, enable_next;
  logic               dir, dir_next;
  logic               rejected;
  res_t               res_next;

  res_t               oq [OQ_DEPTH];
  logic [OQ_AW-1:0]   oq_wr;
  logic [OQ_AW-1:0]   oq_rd;
  logic [OQ_AW:0]     oq_count;
  logic               take;
  logic               out_pop;

  logic [TIMER_W-1:0] half_ext;
  logic [TIMER_W-1:0] dwell_ext;
  logic [TIMER_W-1:0] t_inc;

  assign half_ext  = TIMER_W'(cfg.half_period);
  assign dwell_ext = TIMER_W'(cfg.dwell);
  assign t_inc     = timer + 1'b1;

  assign empty   = (oq_count == '0);
  assign out_pop = pop && !empty;
  assign take    = cmd_valid && ((oq_count != (OQ_AW+1)'(OQ_DEPTH)) || out_pop);
  assign cmd_pop = take;
  assign result  = oq[oq_rd];

  always_comb begin
    logic leg_try;
    logic leg_fail_finish;
    logic finish;
    logic second;
    pos_t stepped;
    mode_next       = mode;
    cur_pos_next    = cur_pos;
    target_next     = target;
    second_tgt_next = second_tgt;
    pending_next    = pending;
    phase_next      = phase;
    timer_next      = timer;
    enable_next     = enable;
    dir_next        = dir;
    rejected        = 1'b0;
    leg_try         = 1'b0;
    leg_fail_finish = 1'b0;
    finish          = 1'b0;
    second          = 1'b0;
    stepped         = dir ? cur_pos + 1'b1 : cur_pos - 1'b1;

    if (cmd.kind == K_TICK) begin
      case (mode)
        M_HOME: begin
          if (t_inc >= half_ext) begin
            timer_next = '0;
            if (phase) begin
              phase_next = 1'b0;
            end else if (!cmd.sw) begin
              cur_pos_next = '0;
              mode_next    = M_IDLE;
            end else begin
              phase_next = 1'b1;
            end
          end else begin
            timer_next = t_inc;
          end
        end
        M_MOVE: begin
          if (t_inc >= half_ext) begin
            timer_next = '0;
            if (phase) begin
              phase_next = 1'b0;
            end else begin
              cur_pos_next = stepped;
              if (stepped == target) begin
                finish = 1'b1;
              end else begin
                phase_next = 1'b1;
              end
            end
          end else begin
            timer_next = t_inc;
          end
        end
        M_DWELL: begin
          if (t_inc >= dwell_ext) begin
            timer_next = '0;
            second     = 1'b1;
          end else begin
            timer_next = t_inc;
          end
        end
        default: begin
        end
      endcase
    end else if (mode != M_IDLE) begin
      rejected = 1'b1;
    end else begin
      case (cmd.kind)
        K_HOME: begin
          enable_next = 1'b1;
          dir_next    = 1'b0;
          if (!cmd.sw) begin
            cur_pos_next = '0;
          end else begin
            mode_next  = M_HOME;
            phase_next = 1'b1;
            timer_next = '0;
          end
        end
        K_MOVE: begin
          target_next  = cmd.tgt_a;
          pending_next = 1'b0;
          leg_try      = 1'b1;
        end
        K_FLOOR: begin
          target_next     = cmd.tgt_a;
          second_tgt_next = cmd.tgt_b;
          pending_next    = 1'b1;
          leg_try         = 1'b1;
          leg_fail_finish = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (leg_try) begin
      if (target_next != cur_pos_next) begin
        enable_next = 1'b1;
        dir_next    = (target_next > cur_pos_next);
        mode_next   = M_MOVE;
        phase_next  = 1'b1;
        timer_next  = '0;
      end else if (leg_fail_finish) begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      phase_next = 1'b0;
      timer_next = '0;
      if (pending_next) begin
        if (cfg.dwell == '0) begin
          second = 1'b1;
        end else begin
          mode_next = M_DWELL;
        end
      end else begin
        mode_next = M_IDLE;
      end
    end

    if (second) begin
      pending_next = 1'b0;
      target_next  = second_tgt_next;
      if (target_next != cur_pos_next) begin
        enable_next = 1'b1;
        dir_next    = (target_next > cur_pos_next);
        mode_next   = M_MOVE;
        phase_next  = 1'b1;
        timer_next  = '0;
      end else begin
        mode_next = M_IDLE;
      end
    end

    res_next.step     = phase_next;
    res_next.dir      = dir_next;
    res_next.en       = enable_next;
    res_next.pos      = cur_pos_next;
    res_next.busy     = (mode_next != M_IDLE);
    res_next.rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      cur_pos    <= '0;
      target     <= '0;
      second_tgt <= '0;
      pending    <= 1'b0;
      phase      <= 1'b0;
      timer      <= '0;
      enable     <= 1'b0;
      dir        <= 1'b0;
    end else if (take) begin
      mode       <= mode_next;
      cur_pos    <= cur_pos_next;
      target     <= target_next;
      second_tgt <= second_tgt_next;
      pending    <= pending_next;
      phase      <= phase_next;
      timer      <= timer_next;
      enable     <= enable_next;
      dir        <= dir_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (take) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (out_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      if (take && !out_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (out_pop && !take) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      oq[oq_wr] <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    oq_count <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("Result queue holds more entries than it has.");

  a_move_enabled: assert property (@(posedge clk) disable iff (rst)
    (mode == M_MOVE) |-> enable)
    else $error("Motion is running with the driver disabled.");

  a_move_has_goal: assert property (@(posedge clk) disable iff (rst)
    (mode == M_MOVE) |-> (target != cur_pos))
    else $error("Move is active although the target is already reached.");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    (take && rejected) |=> (oq_count != '0) && !$past(mode == M_IDLE))
    else $error("A command was dropped while the controller was idle.");
`endif

endmodule
`default_nettype wire

[hw/rtl/stepper_position_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// Step/direction stepper controller with absolute position tracking.
// The input channel takes one item per transfer (push while full is low): either a
// time tick or a home, move or floor command. Every item produces exactly one result
// transfer on the output channel (pop while empty is low) carrying the step, direction
// and enable levels, the tracked position, the busy flag and the rejected flag.
// An item goes through a decode register, a four-entry command queue and the
// execution stage with its two-entry result queue, in that order. One item per cycle
// is sustained while the receiver keeps popping results, as the execution stage
// takes a new command whenever its result queue has room or is being popped.
// When the receiver stalls, results collect in the result queue, then commands in the
// command queue, and full rises once the decode register also holds an item.
// Reset empties both queues, stops all motion, clears position and enable, and loads
// half_period_ticks = 600 and dwell_ticks = 1000000.
// Registers are written over the APB port at byte addresses 0 and 4; writes are
// expected only while no item is in flight.
module stepper_position_controller (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [spc_pkg::OP_W-1:0]     op,
  input  wire logic [spc_pkg::POS_BITS-1:0] destination,
  input  wire logic [spc_pkg::FLOOR_W-1:0]  floor,
  input  wire logic                         switch_level,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              step_out,
  output logic                              dir_out,
  output logic                              enable_out,
  output logic [spc_pkg::POS_BITS-1:0]      position,
  output logic                              busy_res,
  output logic                              rejected,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [spc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [spc_pkg::DATA_W-1:0]   pwdata,
  output logic [spc_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import spc_pkg::*;

  cfg_t cfg;
  logic cfg_write;
  logic front_valid;
  cmd_t front_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  res_t res;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period <= HALF_RESET;
      cfg.dwell       <= DWELL_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_HALF_PERIOD) begin
        cfg.half_period <= pwdata[HALF_W-1:0];
      end else begin
        cfg.dwell <= pwdata[DWELL_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_DWELL) begin
      prdata = DATA_W'(cfg.dwell);
    end else begin
      prdata = DATA_W'(cfg.half_period);
    end
  end

  spc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .destination  (destination),
    .floor        (floor),
    .switch_level (switch_level),
    .cmd_valid    (front_valid),
    .cmd          (front_cmd),
    .cmd_full     (q_full)
  );

  spc_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (front_valid),
    .cmd_in  (front_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (q_cmd),
    .valid   (q_valid)
  );

  spc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (res)
  );

  assign step_out   = res.step;
  assign dir_out    = res.dir;
  assign enable_out = res.en;
  assign position   = res.pos;
  assign busy_res   = res.busy;
  assign rejected   = res.rejected;

endmodule
`default_nettype wire

[verif/stepper_position_controller_test.sv]
`timescale 1ns / 1ps
module stepper_position_controller_test;
  import spc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POS_MAX = (1 << POS_BITS) - 1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_HOMING,
    MODE_MOVING,
    MODE_DWELLING
  } motion_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [OP_W-1:0] op = OP_TICK;
  pos_t destination = '0;
  logic [FLOOR_W-1:0] floor_sel = '0;
  logic switch_level = 1'b1;
  logic empty;
  logic pop = 1'b0;
  logic step_out;
  logic dir_out;
  logic enable_out;
  pos_t position;
  logic busy_res;
  logic rejected;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  logic [HALF_W-1:0] half_ticks;
  logic [DWELL_W-1:0] dwell_len;
  motion_mode_t mode_q;
  pos_t pos_q;
  pos_t tgt_q;
  pos_t tgt2_q;
  logic leg2_q;
  logic phase_q;
  logic en_q;
  logic dir_q;
  logic [TIMER_W-1:0] timer_q;

  res_t status_queue[$];
  int failures = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_count = 0;

  stepper_position_controller i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .destination  (destination),
    .floor        (floor_sel),
    .switch_level (switch_level),
    .empty        (empty),
    .pop          (pop),
    .step_out     (step_out),
    .dir_out      (dir_out),
    .enable_out   (enable_out),
    .position     (position),
    .busy_res     (busy_res),
    .rejected     (rejected),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  function automatic void reset_motor();
    half_ticks = HALF_RESET;
    dwell_len = DWELL_RESET;
    mode_q = MODE_IDLE;
    pos_q = '0;
    tgt_q = '0;
    tgt2_q = '0;
    leg2_q = 1'b0;
    phase_q = 1'b0;
    timer_q = '0;
    en_q = 1'b0;
    dir_q = 1'b0;
  endfunction

  function automatic void begin_pulse();
    phase_q = 1'b1;
    timer_q = '0;
  endfunction

  function automatic bit begin_leg();
    if (tgt_q == pos_q) begin
      return 1'b0;
    end
    en_q = 1'b1;
    dir_q = tgt_q > pos_q;
    mode_q = MODE_MOVING;
    begin_pulse();
    return 1'b1;
  endfunction

  function automatic void begin_second_leg();
    leg2_q = 1'b0;
    tgt_q = tgt2_q;
    if (!begin_leg()) begin
      mode_q = MODE_IDLE;
    end
  endfunction

  function automatic void finish_leg();
    phase_q = 1'b0;
    timer_q = '0;
    if (leg2_q) begin
      if (dwell_len == '0) begin
        begin_second_leg();
      end else begin
        mode_q = MODE_DWELLING;
      end
    end else begin
      mode_q = MODE_IDLE;
    end
  endfunction

  function automatic bit half_done();
    timer_q = timer_q + 1'b1;
    return timer_q >= TIMER_W'(half_ticks);
  endfunction

  function automatic void advance_tick(input logic sw);
    case (mode_q)
      MODE_HOMING: begin
        if (half_done()) begin
          timer_q = '0;
          if (phase_q) begin
            phase_q = 1'b0;
          end else if (!sw) begin
            pos_q = '0;
            mode_q = MODE_IDLE;
          end else begin
            begin_pulse();
          end
        end
      end
      MODE_MOVING: begin
        if (half_done()) begin
          timer_q = '0;
          if (phase_q) begin
            phase_q = 1'b0;
          end else begin
            pos_q = dir_q ? pos_q + 1'b1 : pos_q - 1'b1;
            if (pos_q == tgt_q) begin
              finish_leg();
            end else begin
              begin_pulse();
            end
          end
        end
      end
      MODE_DWELLING: begin
        timer_q = timer_q + 1'b1;
        if (timer_q >= dwell_len) begin
          timer_q = '0;
          begin_second_leg();
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic res_t predict_status(input logic [OP_W-1:0] item_op, input pos_t item_dest,
                                          input logic [FLOOR_W-1:0] item_floor,
                                          input logic item_sw);
    res_t r;
    logic dropped;
    dropped = 1'b0;
    if (item_op == OP_TICK) begin
      advance_tick(item_sw);
    end else if (mode_q != MODE_IDLE) begin
      dropped = 1'b1;
    end else if (item_op == OP_HOME) begin
      en_q = 1'b1;
      dir_q = 1'b0;
      if (!item_sw) begin
        pos_q = '0;
      end else begin
        mode_q = MODE_HOMING;
        begin_pulse();
      end
    end else if (item_op == OP_MOVE) begin
      tgt_q = item_dest;
      leg2_q = 1'b0;
      void'(begin_leg());
    end else if (int'(item_floor) < NUM_FLOORS && int'(item_floor) < TABLE_ROWS) begin
      tgt_q = pos_t'(FLOOR_TABLE[item_floor][0]);
      tgt2_q = pos_t'(FLOOR_TABLE[item_floor][1]);
      leg2_q = 1'b1;
      if (!begin_leg()) begin
        finish_leg();
      end
    end
    r.step = phase_q;
    r.dir = dir_q;
    r.en = en_q;
    r.pos = pos_q;
    r.busy = mode_q != MODE_IDLE;
    r.rejected = dropped;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] reg_addr(input logic idx);
    return ADDR_W'({idx, 2'b00});
  endfunction

  task automatic send_item(input logic [OP_W-1:0] item_op, input pos_t item_dest,
                           input logic [FLOOR_W-1:0] item_floor, input logic item_sw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    op <= item_op;
    destination <= item_dest;
    floor_sel <= item_floor;
    switch_level <= item_sw;
    do @(posedge clk); while (full);
    status_queue.push_back(predict_status(item_op, item_dest, item_floor, item_sw));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= reg_addr(idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_HALF_PERIOD) begin
      half_ticks = value[HALF_W-1:0];
    end else begin
      dwell_len = value[DWELL_W-1:0];
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic idx);
    logic [DATA_W-1:0] want;
    want = (idx == REG_HALF_PERIOD) ? DATA_W'(half_ticks) : DATA_W'(dwell_len);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= reg_addr(idx);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata: expected %0d, got %0d", want, prdata);
      failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] half, input logic [DATA_W-1:0] dwell);
    wait_drained();
    write_reg(REG_HALF_PERIOD, half);
    write_reg(REG_DWELL, dwell);
    check_reg(REG_HALF_PERIOD);
    check_reg(REG_DWELL);
  endtask

  task automatic run_ticks(input int count, input logic sw);
    repeat (count) send_item(OP_TICK, pos_t'($urandom), FLOOR_W'($urandom), sw);
  endtask

  task automatic run_to_idle(input bit random_sw);
    while (mode_q != MODE_IDLE) begin
      send_item(OP_TICK, pos_t'($urandom), FLOOR_W'($urandom),
                random_sw ? ($urandom_range(0, 7) != 0) : 1'b0);
    end
  endtask

  task automatic command(input logic [OP_W-1:0] item_op, input pos_t item_dest,
                         input logic [FLOOR_W-1:0] item_floor, input logic item_sw);
    send_item(item_op, item_dest, item_floor, item_sw);
    run_to_idle(1'b1);
  endtask

  task automatic test_reset_state();
    check_reg(REG_HALF_PERIOD);
    check_reg(REG_DWELL);
    send_item(OP_TICK, '0, '0, 1'b1);
    send_item(OP_MOVE, '0, '0, 1'b1);
    send_item(OP_FLOOR, '0, FLOOR_W'(6), 1'b1);
    send_item(OP_FLOOR, '1, FLOOR_W'(7), 1'b1);
    send_item(OP_HOME, '0, '0, 1'b0);
  endtask

  task automatic test_moves();
    set_config(1, 0);
    command(OP_MOVE, pos_t'(12), '0, 1'b1);
    command(OP_MOVE, '0, '0, 1'b0);
    command(OP_MOVE, pos_t'(5), '0, 1'b1);
  endtask

  task automatic test_busy_commands();
    send_item(OP_MOVE, pos_q + pos_t'(8), '0, 1'b1);
    run_ticks(3, 1'b1);
    send_item(OP_HOME, '0, '0, 1'b1);
    send_item(OP_MOVE, pos_t'(100), '0, 1'b0);
    send_item(OP_FLOOR, '0, FLOOR_W'(2), 1'b1);
    send_item(OP_FLOOR, '0, FLOOR_W'(7), 1'b1);
    run_to_idle(1'b1);
  endtask

  task automatic test_homing();
    send_item(OP_HOME, '0, '0, 1'b1);
    run_ticks(9, 1'b1);
    run_to_idle(1'b0);
    command(OP_HOME, '0, '0, 1'b1);
  endtask

  task automatic test_floors();
    command(OP_MOVE, pos_t'(250), '0, 1'b1);
    set_config(1, 3);
    send_item(OP_FLOOR, '0, FLOOR_W'(5), 1'b1);
    while (mode_q != MODE_DWELLING) send_item(OP_TICK, '0, '0, 1'b1);
    send_item(OP_MOVE, pos_t'(900), '0, 1'b1);
    run_to_idle(1'b1);
    set_config(1, 0);
    command(OP_FLOOR, '0, FLOOR_W'(5), 1'b1);
  endtask

  task automatic test_half_period_zero();
    set_config(0, 1);
    command(OP_MOVE, pos_q + pos_t'(3), '0, 1'b1);
    command(OP_MOVE, pos_q - pos_t'(2), '0, 1'b1);
  endtask

  task automatic test_config_extremes();
    set_config(65535, 1048575);
    send_item(OP_MOVE, pos_q - 1'b1, '0, 1'b1);
    run_ticks(20, 1'b1);
    send_item(OP_HOME, '0, '0, 1'b0);
  endtask

  task automatic random_sequence();
    int pick;
    int d;
    pos_t dest;
    logic [OP_W-1:0] cmd;
    pick = $urandom_range(0, 19);
    d = $urandom_range(0, 24);
    if (pick < 3) begin
      cmd = OP_TICK;
    end else if (pick < 6) begin
      cmd = OP_HOME;
    end else if (pick < 15) begin
      cmd = OP_MOVE;
    end else begin
      cmd = OP_FLOOR;
    end
    if (cmd != OP_MOVE) begin
      dest = pos_t'($urandom);
    end else if (int'(pos_q) >= d && (int'(pos_q) + d > POS_MAX || $urandom_range(0, 1) == 1)) begin
      dest = pos_q - pos_t'(d);
    end else begin
      dest = pos_q + pos_t'(d);
    end
    send_item(cmd, dest, FLOOR_W'($urandom_range(NUM_FLOORS, 7)), $urandom_range(0, 3) != 0);
    while (mode_q != MODE_IDLE) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item(OP_W'($urandom_range(OP_HOME, OP_FLOOR)), pos_t'($urandom),
                  FLOOR_W'($urandom), $urandom_range(0, 1));
      end else begin
        send_item(OP_TICK, pos_t'($urandom), FLOOR_W'($urandom), $urandom_range(0, 3) != 0);
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      wait_drained();
    end
  endtask

  task automatic test_random();
    set_config(1, 0);
    repeat (3) random_sequence();
    set_config(2, 5);
    repeat (3) random_sequence();
    set_config(0, 1);
    repeat (3) random_sequence();
    set_config(1, 17);
    repeat (3) random_sequence();
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (status_queue.size() == 0) begin
          $error("result transfer with no prediction waiting");
          failures++;
        end else begin
          want = status_queue.pop_front();
          if (step_out !== want.step) begin
            $error("step_out: expected %0d, got %0d", want.step, step_out);
            failures++;
          end
          if (dir_out !== want.dir) begin
            $error("dir_out: expected %0d, got %0d", want.dir, dir_out);
            failures++;
          end
          if (enable_out !== want.en) begin
            $error("enable_out: expected %0d, got %0d", want.en, enable_out);
            failures++;
          end
          if (position !== want.pos) begin
            $error("position: expected %0d, got %0d", want.pos, position);
            failures++;
          end
          if (busy_res !== want.busy) begin
            $error("busy_res: expected %0d, got %0d", want.busy, busy_res);
            failures++;
          end
          if (rejected !== want.rejected) begin
            $error("rejected: expected %0d, got %0d", want.rejected, rejected);
            failures++;
          end
        end
      end
      stall_count++;
      if (stall_count >= 64) begin
        stall_count = 0;
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 3) != 0;
        2: pop <= $urandom_range(0, 3) == 0;
        default: pop <= (stall_count % 3) == 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("stepper_position_controller test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_motor();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_moves();
    test_busy_commands();
    test_homing();
    test_floors();
    test_half_period_zero();
    test_random();
    test_config_extremes();
    wait_drained();
    if (status_queue.size() != 0) begin
      failures++;
    end
    if (failures == 0) begin
      $display("stepper_position_controller test passed");
    end else begin
      $display("stepper_position_controller test failed");
    end
    $finish;
  end

endmodule

[stepper_position_controller.f]
hw/rtl/spc_pkg.sv
hw/rtl/spc_front.sv
hw/rtl/spc_cmd_fifo.sv
hw/rtl/spc_back.sv
hw/rtl/stepper_position_controller.sv
verif/stepper_position_controller_test.sv
